@@ rtl/wrp_pkg.sv @@
package wrp_pkg;

    // Parse phases, in the order the file lays them out
    typedef enum logic [2:0] {
        PH_RIFF  = 3'd0,
        PH_FSIZE = 3'd1,
        PH_WAVE  = 3'd2,
        PH_HDR   = 3'd3,
        PH_FMT   = 3'd4,
        PH_SKIP  = 3'd5,
        PH_DATA  = 3'd6,
        PH_HOLD  = 3'd7
    } wrp_phase_t;

    // Result status codes
    localparam logic [3:0] ST_NONE       = 4'd0;
    localparam logic [3:0] ST_AUDIO      = 4'd1;
    localparam logic [3:0] ST_DONE       = 4'd2;
    localparam logic [3:0] ST_BAD_RIFF   = 4'd3;
    localparam logic [3:0] ST_SHORT_SIZE = 4'd4;
    localparam logic [3:0] ST_BAD_WAVE   = 4'd5;
    localparam logic [3:0] ST_FMT_SHORT  = 4'd6;
    localparam logic [3:0] ST_NON_PCM    = 4'd7;
    localparam logic [3:0] ST_NO_FMT     = 4'd8;
    localparam logic [3:0] ST_DATA_TRUNC = 4'd9;
    localparam logic [3:0] ST_NO_CHUNKS  = 4'd10;

    // Tags as they arrive, first byte most significant
    localparam logic [31:0] TAG_RIFF = 32'h5249_4646;
    localparam logic [31:0] TAG_WAVE = 32'h5741_5645;
    localparam logic [31:0] TAG_FMT  = 32'h666D_7420;
    localparam logic [31:0] TAG_DATA = 32'h6461_7461;

    localparam logic [15:0] PCM_CODE     = 16'd1;
    localparam logic [31:0] FMT_BASE_LEN = 32'd16;

    typedef struct packed {
        logic [3:0]  status;
        logic [7:0]  audio_byte;
        logic [15:0] channel_count;
        logic [31:0] sample_rate;
        logic [15:0] bits_per_sample;
        logic [31:0] data_size;
    } wrp_result_t;

endpackage

@@ rtl/wrp_parse.sv @@
module wrp_parse
    import wrp_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        step,
    input  logic [7:0]  file_byte,
    input  logic        end_of_file,
    output wrp_result_t result
);

    wrp_phase_t  phase_reg, phase_next;
    logic [4:0]  idx_reg, idx_next;
    logic [31:0] tag_reg, tag_next;
    logic [31:0] size_reg, size_next;
    logic [32:0] remain_reg, remain_next;
    logic        fmt_seen_reg, fmt_seen_next;
    logic [15:0] fmt_code_reg, fmt_code_next;
    logic [15:0] chan_reg, chan_next;
    logic [31:0] rate_reg, rate_next;
    logic [15:0] bits_reg, bits_next;
    logic [31:0] dsize_reg, dsize_next;

    logic [4:0]  idx_inc;
    logic [31:0] tag_push;
    logic [31:0] size_push;
    logic [32:0] remain_dec;
    logic [32:0] unknown_len;
    logic [32:0] fmt_extra;
    logic        pcm_bad;
    logic [3:0]  status;
    logic [7:0]  audio;

    assign idx_inc     = idx_reg + 5'd1;
    assign tag_push    = {tag_reg[23:0], file_byte};
    assign size_push   = {file_byte, size_reg[31:8]};
    assign remain_dec  = remain_reg - 33'd1;
    // Unknown chunks pad to even length; 33 bits keep the largest size from wrapping
    assign unknown_len = {1'b0, size_push} + {32'd0, size_push[0]};
    assign fmt_extra   = (size_reg > FMT_BASE_LEN) ? {1'b0, size_reg - FMT_BASE_LEN} : 33'd0;
    assign pcm_bad     = (idx_reg == 5'd1) && ({file_byte, fmt_code_reg[7:0]} != PCM_CODE);

    // Next phase
    always_comb
    begin
        phase_next = phase_reg;
        unique case (phase_reg)
            PH_RIFF:
            begin
                if (idx_reg == 5'd3)
                    phase_next = (tag_push == TAG_RIFF) ? PH_FSIZE : PH_HOLD;
            end
            PH_FSIZE:
            begin
                if (idx_reg == 5'd3)
                    phase_next = PH_WAVE;
            end
            PH_WAVE:
            begin
                if (idx_reg == 5'd3)
                    phase_next = (tag_reg[23:0] == TAG_WAVE[31:8] && file_byte == TAG_WAVE[7:0])
                                 ? PH_HDR : PH_HOLD;
            end
            PH_HDR:
            begin
                if (idx_reg == 5'd7)
                begin
                    priority if (tag_reg == TAG_FMT)
                        phase_next = PH_FMT;
                    else if (tag_reg == TAG_DATA)
                        phase_next = (!fmt_seen_reg || size_push == 32'd0) ? PH_HOLD : PH_DATA;
                    else
                        phase_next = (unknown_len != 33'd0) ? PH_SKIP : PH_HDR;
                end
            end
            PH_FMT:
            begin
                priority if (pcm_bad)
                    phase_next = PH_HOLD;
                else if (idx_reg == 5'd15)
                    phase_next = (fmt_extra != 33'd0) ? PH_SKIP : PH_HDR;
                else
                    phase_next = PH_FMT;
            end
            PH_SKIP:
            begin
                if (remain_dec == 33'd0)
                    phase_next = PH_HDR;
            end
            PH_DATA:
            begin
                if (remain_dec == 33'd0)
                    phase_next = PH_HOLD;
            end
            PH_HOLD:
            begin
                phase_next = PH_HOLD;
            end
        endcase
    end

    // Datapath and result
    always_comb
    begin
        idx_next      = idx_reg;
        tag_next      = tag_reg;
        size_next     = size_reg;
        remain_next   = remain_reg;
        fmt_seen_next = fmt_seen_reg;
        fmt_code_next = fmt_code_reg;
        chan_next     = chan_reg;
        rate_next     = rate_reg;
        bits_next     = bits_reg;
        dsize_next    = dsize_reg;
        status        = ST_NONE;
        audio         = 8'd0;

        unique case (phase_reg)
            PH_RIFF, PH_WAVE:
            begin
                tag_next = tag_push;
                idx_next = (idx_reg == 5'd3) ? 5'd0 : idx_inc;
                if (idx_reg == 5'd3 && phase_next == PH_HOLD)
                    status = (phase_reg == PH_RIFF) ? ST_BAD_RIFF : ST_BAD_WAVE;
            end
            PH_FSIZE:
            begin
                size_next = size_push;
                idx_next  = (idx_reg == 5'd3) ? 5'd0 : idx_inc;
            end
            PH_HDR:
            begin
                if (idx_reg < 5'd4)
                    tag_next = tag_push;
                else
                    size_next = size_push;
                idx_next = idx_inc;
                if (idx_reg == 5'd7)
                begin
                    idx_next = 5'd0;
                    priority if (tag_reg == TAG_FMT)
                        idx_next = 5'd0;
                    else if (tag_reg == TAG_DATA)
                    begin
                        priority if (!fmt_seen_reg)
                            status = ST_NO_FMT;
                        else
                        begin
                            dsize_next = size_push;
                            if (size_push == 32'd0)
                                status = ST_DONE;
                            else
                                remain_next = {1'b0, size_push};
                        end
                    end
                    else
                        remain_next = unknown_len;
                end
            end
            PH_FMT:
            begin
                unique case (idx_reg)
                    5'd0:    fmt_code_next[7:0] = file_byte;
                    5'd1:    fmt_code_next[15:8] = file_byte;
                    5'd2:    chan_next[7:0] = file_byte;
                    5'd3:    chan_next[15:8] = file_byte;
                    5'd4:    rate_next[7:0] = file_byte;
                    5'd5:    rate_next[15:8] = file_byte;
                    5'd6:    rate_next[23:16] = file_byte;
                    5'd7:    rate_next[31:24] = file_byte;
                    5'd14:   bits_next[7:0] = file_byte;
                    5'd15:   bits_next[15:8] = file_byte;
                    default: ;
                endcase
                priority if (pcm_bad)
                begin
                    idx_next = 5'd0;
                    status   = ST_NON_PCM;
                end
                else if (idx_reg == 5'd15)
                begin
                    idx_next      = 5'd0;
                    fmt_seen_next = 1'b1;
                    remain_next   = fmt_extra;
                end
                else
                    idx_next = idx_inc;
            end
            PH_SKIP:
            begin
                remain_next = remain_dec;
            end
            PH_DATA:
            begin
                audio       = file_byte;
                remain_next = remain_dec;
                status      = (remain_dec == 33'd0) ? ST_DONE : ST_AUDIO;
            end
            PH_HOLD:
            begin
                status = ST_NONE;
            end
        endcase

        // Early end of file: name the read that would fail next
        if (end_of_file && status < ST_DONE)
        begin
            unique case (phase_next)
                PH_RIFF:  status = ST_BAD_RIFF;
                PH_FSIZE: status = ST_SHORT_SIZE;
                PH_WAVE:  status = ST_BAD_WAVE;
                PH_FMT:   status = ST_FMT_SHORT;
                PH_DATA:
                begin
                    status = ST_DATA_TRUNC;
                    audio  = 8'd0;
                end
                PH_HDR, PH_SKIP: status = ST_NO_CHUNKS;
                PH_HOLD:  status = ST_NONE;
            endcase
        end
    end

    assign result = {status, audio, chan_next, rate_next, bits_next, dsize_next};

    // Advance on each byte; a byte marked last restarts the parser
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg    <= PH_RIFF;
            idx_reg      <= 5'd0;
            tag_reg      <= 32'd0;
            size_reg     <= 32'd0;
            remain_reg   <= 33'd0;
            fmt_seen_reg <= 1'b0;
            fmt_code_reg <= 16'd0;
            chan_reg     <= 16'd0;
            rate_reg     <= 32'd0;
            bits_reg     <= 16'd0;
            dsize_reg    <= 32'd0;
        end
        else if (step)
        begin
            if (end_of_file)
            begin
                phase_reg    <= PH_RIFF;
                idx_reg      <= 5'd0;
                tag_reg      <= 32'd0;
                size_reg     <= 32'd0;
                remain_reg   <= 33'd0;
                fmt_seen_reg <= 1'b0;
                fmt_code_reg <= 16'd0;
                chan_reg     <= 16'd0;
                rate_reg     <= 32'd0;
                bits_reg     <= 16'd0;
                dsize_reg    <= 32'd0;
            end
            else
            begin
                phase_reg    <= phase_next;
                idx_reg      <= idx_next;
                tag_reg      <= tag_next;
                size_reg     <= size_next;
                remain_reg   <= remain_next;
                fmt_seen_reg <= fmt_seen_next;
                fmt_code_reg <= fmt_code_next;
                chan_reg     <= chan_next;
                rate_reg     <= rate_next;
                bits_reg     <= bits_next;
                dsize_reg    <= dsize_next;
            end
        end
    end

`ifndef SYNTH
    a_restart: assert property (@(posedge clk) disable iff (!rst_n)
        step && end_of_file |=> phase_reg == PH_RIFF && idx_reg == 5'd0 && !fmt_seen_reg)
        else $error("parser did not restart after last byte");

    a_skip_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
        (phase_reg == PH_SKIP || phase_reg == PH_DATA) |-> remain_reg != 33'd0)
        else $error("skip or data phase with nothing remaining");

    a_idx_range: assert property (@(posedge clk) disable iff (!rst_n)
        (phase_reg == PH_HDR |-> idx_reg < 5'd8) and (phase_reg == PH_FMT |-> idx_reg < 5'd16))
        else $error("field index out of range");
`endif

endmodule

@@ rtl/wav_riff_stream_parser_top.sv @@
// Channel   Dir  Payload                                          Handshake
// s_axis    in   tdata[7:0] file_byte, tlast end_of_file          tvalid/tready
// m_axis    out  tuser[3:0] status, tdata[103:0] audio and header tvalid/tready
//
// One request per cycle while m_axis is ready; every input byte yields exactly one result.
// Each request passes an input register, then the parse step and the result register.
// The parse step is a single state update per byte, so nothing limits throughput
// except downstream backpressure; the input register holds one byte while the
// result register waits, and both drain together when m_axis_tready returns.
// Reset (rst_n low, asynchronous) empties both registers and puts the parser
// at the RIFF tag; a request with tlast high returns the parser there after its result.
module wav_riff_stream_parser_top
    import wrp_pkg::*;
(
    input  logic         clk,
    input  logic         rst_n,
    input  logic         s_axis_tvalid,
    output logic         s_axis_tready,
    input  logic [7:0]   s_axis_tdata,   // [7:0] file_byte
    input  logic         s_axis_tlast,   // end_of_file
    output logic         m_axis_tvalid,
    input  logic         m_axis_tready,
    output logic [103:0] m_axis_tdata,   // [7:0] audio_byte, [23:8] channel_count,
                                         // [55:24] sample_rate, [71:56] bits_per_sample,
                                         // [103:72] data_size
    output logic [3:0]   m_axis_tuser    // [3:0] status
);

    logic        in_valid_reg;
    logic [7:0]  in_byte_reg;
    logic        in_last_reg;
    logic        out_valid_reg;
    wrp_result_t out_result_reg;

    logic        advance;
    logic        step;
    wrp_result_t result;

    // The result register frees up when empty or when its request is taken
    assign advance       = !out_valid_reg || m_axis_tready;
    assign step          = in_valid_reg && advance;
    assign s_axis_tready = !in_valid_reg || advance;

    // Input register: hold the byte while the result side stalls
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg <= 1'b0;
        end
        else if (s_axis_tready)
        begin
            in_valid_reg <= s_axis_tvalid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (s_axis_tready && s_axis_tvalid)
        begin
            in_byte_reg <= s_axis_tdata;
            in_last_reg <= s_axis_tlast;
        end
    end

    wrp_parse u_parse (
        .clk         (clk),
        .rst_n       (rst_n),
        .step        (step),
        .file_byte   (in_byte_reg),
        .end_of_file (in_last_reg),
        .result      (result)
    );

    // Result register: advance when free, otherwise hold the pending request
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (advance)
        begin
            out_valid_reg <= in_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (step)
        begin
            out_result_reg <= result;
        end
    end

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tuser  = out_result_reg.status;
    assign m_axis_tdata  = {out_result_reg.data_size,
                            out_result_reg.bits_per_sample,
                            out_result_reg.sample_rate,
                            out_result_reg.channel_count,
                            out_result_reg.audio_byte};

`ifndef SYNTH
    a_audio_zero: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && m_axis_tuser != ST_AUDIO && m_axis_tuser != ST_DONE
        |-> m_axis_tdata[7:0] == 8'd0)
        else $error("audio byte set on a result that carries no audio");

    a_in_hold: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid_reg && !advance |=> in_valid_reg && $stable(in_byte_reg))
        else $error("stalled input request lost");

    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && !m_axis_tready
        |=> m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tuser))
        else $error("stalled result request changed");
`endif

endmodule

@@ verif/wav_riff_stream_parser_top_tb.sv @@
`timescale 1ns / 100ps

module wav_riff_stream_parser_top_tb;
    import wrp_pkg::*;

    // One byte request toward the parser, with its end-of-file mark
    typedef struct {
        logic [7:0] data;
        logic       last;
        logic       drain;   // hold off until every pending result is out
    } wav_req_t;

    logic         clk = 1'b0;
    logic         rst_n = 1'b0;
    logic         s_axis_tvalid = 1'b0;
    logic         s_axis_tready;
    logic [7:0]   s_axis_tdata = 8'd0;    // [7:0] file_byte
    logic         s_axis_tlast = 1'b0;    // end_of_file
    logic         m_axis_tvalid;
    logic         m_axis_tready = 1'b0;
    logic [103:0] m_axis_tdata;           // [7:0] audio_byte, [23:8] channel_count,
                                          // [55:24] sample_rate, [71:56] bits_per_sample,
                                          // [103:72] data_size
    logic [3:0]   m_axis_tuser;           // [3:0] status

    wav_riff_stream_parser_top dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tlast  (s_axis_tlast),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    // Byte requests still to send, results the parser owes us, and failures
    wav_req_t    req_q[$];
    wrp_result_t parsed_results_q[$];
    logic [7:0]  file_bytes[$];
    int unsigned error_count = 0;
    logic        in_taken = 1'b0;

    // ------------------------------------------------------------------
    // Header parser mirror: phase, byte counter, shift registers, captures
    // ------------------------------------------------------------------
    wrp_phase_t  p_phase;
    logic [4:0]  p_idx;
    logic [31:0] p_tag;
    logic [31:0] p_size;
    logic [32:0] p_remain;
    logic        p_fmt_seen;
    logic [15:0] p_fmt_code;
    logic [15:0] p_channels;
    logic [31:0] p_rate;
    logic [15:0] p_bits;
    logic [31:0] p_data_size;

    task automatic clear_parser();
        p_phase     = PH_RIFF;
        p_idx       = 5'd0;
        p_tag       = 32'd0;
        p_size      = 32'd0;
        p_remain    = 33'd0;
        p_fmt_seen  = 1'b0;
        p_fmt_code  = 16'd0;
        p_channels  = 16'd0;
        p_rate      = 32'd0;
        p_bits      = 16'd0;
        p_data_size = 32'd0;
    endtask

    // Advance the mirror by one file byte and return the result it must produce
    task automatic parse_wav_byte(input logic [7:0] b, input logic eof,
                                  output wrp_result_t r);
        logic [3:0] st;
        logic [7:0] ab;
        logic [4:0] i;
        st = ST_NONE;
        ab = 8'd0;
        i  = p_idx;
        case (p_phase)
            PH_RIFF, PH_WAVE:
            begin
                p_tag = {p_tag[23:0], b};
                p_idx = i + 5'd1;
                if (p_idx == 5'd4)
                begin
                    p_idx = 5'd0;
                    if (p_phase == PH_RIFF)
                    begin
                        if (p_tag != TAG_RIFF)
                        begin
                            st = ST_BAD_RIFF;
                            p_phase = PH_HOLD;
                        end
                        else
                            p_phase = PH_FSIZE;
                    end
                    else if (p_tag != TAG_WAVE)
                    begin
                        st = ST_BAD_WAVE;
                        p_phase = PH_HOLD;
                    end
                    else
                        p_phase = PH_HDR;
                end
            end
            PH_FSIZE:
            begin
                p_size = {b, p_size[31:8]};
                p_idx = i + 5'd1;
                if (p_idx == 5'd4)
                begin
                    p_idx = 5'd0;
                    p_phase = PH_WAVE;
                end
            end
            PH_HDR:
            begin
                // tag first, then the little-endian size
                if (i < 5'd4)
                    p_tag = {p_tag[23:0], b};
                else
                    p_size = {b, p_size[31:8]};
                p_idx = i + 5'd1;
                if (p_idx >= 5'd8)
                begin
                    p_idx = 5'd0;
                    if (p_tag == TAG_FMT)
                        p_phase = PH_FMT;
                    else if (p_tag == TAG_DATA)
                    begin
                        if (!p_fmt_seen)
                        begin
                            st = ST_NO_FMT;
                            p_phase = PH_HOLD;
                        end
                        else
                        begin
                            p_data_size = p_size;
                            if (p_size == 32'd0)
                            begin
                                st = ST_DONE;
                                p_phase = PH_HOLD;
                            end
                            else
                            begin
                                p_remain = {1'b0, p_size};
                                p_phase = PH_DATA;
                            end
                        end
                    end
                    else
                    begin
                        // unknown chunk: pad to even, 33 bits so all-ones does not wrap
                        p_remain = {1'b0, p_size} + p_size[0];
                        p_phase = (p_remain != 33'd0) ? PH_SKIP : PH_HDR;
                    end
                end
            end
            PH_FMT:
            begin
                if (i < 5'd2)
                    p_fmt_code[{i[0], 3'b000} +: 8] = b;
                else if (i < 5'd4)
                    p_channels[{i[0], 3'b000} +: 8] = b;
                else if (i < 5'd8)
                    p_rate[{i[1:0], 3'b000} +: 8] = b;
                else if (i >= 5'd14)
                    p_bits[{i[0], 3'b000} +: 8] = b;
                p_idx = i + 5'd1;
                if (i == 5'd1 && p_fmt_code != PCM_CODE)
                begin
                    p_idx = 5'd0;
                    st = ST_NON_PCM;
                    p_phase = PH_HOLD;
                end
                else if (p_idx >= 5'd16)
                begin
                    // short fmt sizes still read 16 bytes and skip nothing
                    p_idx = 5'd0;
                    p_fmt_seen = 1'b1;
                    p_remain = (p_size > FMT_BASE_LEN) ? {1'b0, p_size - FMT_BASE_LEN} : 33'd0;
                    p_phase = (p_remain != 33'd0) ? PH_SKIP : PH_HDR;
                end
            end
            PH_SKIP:
            begin
                p_remain = p_remain - 33'd1;
                if (p_remain == 33'd0)
                    p_phase = PH_HDR;
            end
            PH_DATA:
            begin
                ab = b;
                p_remain = p_remain - 33'd1;
                if (p_remain == 33'd0)
                begin
                    st = ST_DONE;
                    p_phase = PH_HOLD;
                end
                else
                    st = ST_AUDIO;
            end
            default:
                p_phase = PH_HOLD;
        endcase

        // End of file before anything finished: name the read that would fail next
        if (eof && st < ST_DONE)
        begin
            case (p_phase)
                PH_RIFF:  st = ST_BAD_RIFF;
                PH_FSIZE: st = ST_SHORT_SIZE;
                PH_WAVE:  st = ST_BAD_WAVE;
                PH_FMT:   st = ST_FMT_SHORT;
                PH_DATA:
                begin
                    st = ST_DATA_TRUNC;
                    ab = 8'd0;
                end
                PH_HDR, PH_SKIP: st = ST_NO_CHUNKS;
                default: ;
            endcase
        end

        r = {st, ab, p_channels, p_rate, p_bits, p_data_size};
        if (eof)
            clear_parser();
    endtask

    // ------------------------------------------------------------------
    // File builders: append bytes to file_bytes, then turn them into requests
    // ------------------------------------------------------------------
    task automatic push_le(input logic [31:0] v, input int n);
        for (int k = 0; k < n; k++)
            file_bytes.push_back(v[8*k +: 8]);
    endtask

    // Tags go out first byte first; now and then damage one of them
    task automatic push_tag(input logic [31:0] v, input bit may_damage);
        for (int k = 3; k >= 0; k--)
            file_bytes.push_back(v[8*k +: 8]);
        if (may_damage && $urandom_range(0, 19) == 0)
            file_bytes[file_bytes.size() - 1 - $urandom_range(0, 3)] ^= 8'($urandom_range(1, 255));
    endtask

    task automatic push_random(input int n);
        for (int k = 0; k < n; k++)
            file_bytes.push_back(8'($urandom));
    endtask

    function automatic logic [31:0] pick_value();
        case ($urandom_range(0, 5))
            0:       return 32'd0;
            1:       return 32'hFFFF_FFFF;
            default: return $urandom;
        endcase
    endfunction

    task automatic add_fmt_chunk();
        logic [31:0] sz;
        logic [15:0] code;
        case ($urandom_range(0, 9))
            0:       sz = $urandom_range(0, 15);
            1, 2:    sz = 16 + $urandom_range(1, 7);
            3:       sz = pick_value();
            default: sz = 32'd16;
        endcase
        case ($urandom_range(0, 9))
            0:       code = 16'($urandom);
            1:       code = 16'h0101;   // low byte right, high byte wrong
            default: code = PCM_CODE;
        endcase
        push_tag(TAG_FMT, 1'b0);
        push_le(sz, 4);
        push_le(code, 2);
        push_le(pick_value(), 2);
        push_le(pick_value(), 4);
        push_random(6);                 // byte rate and block align are not kept
        push_le(pick_value(), 2);
        if (sz > 32'd16 && sz < 32'd64)
            push_random(sz - 16);
    endtask

    task automatic add_other_chunk();
        logic [31:0] sz;
        case ($urandom_range(0, 9))
            0:       sz = 32'd0;
            1:       sz = 32'hFFFF_FFFF;
            2:       sz = $urandom;
            default: sz = $urandom_range(1, 9);
        endcase
        push_tag($urandom, 1'b0);
        push_le(sz, 4);
        push_random((sz < 32'd64) ? sz + sz[0] : $urandom_range(0, 6));
    endtask

    task automatic add_data_chunk();
        logic [31:0] sz;
        case ($urandom_range(0, 15))
            0, 1:    sz = 32'd0;
            2:       sz = pick_value();
            default: sz = $urandom_range(1, 24);
        endcase
        push_tag(TAG_DATA, 1'b0);
        push_le(sz, 4);
        push_random((sz < 32'd64) ? sz : $urandom_range(0, 8));
    endtask

    // Turn file_bytes into requests; the final one carries end-of-file
    task automatic queue_file(input bit may_cut, input bit drain);
        wav_req_t req;
        int       n;
        n = file_bytes.size();
        if (may_cut && $urandom_range(0, 3) == 0)
            n = $urandom_range(1, n);
        for (int k = 0; k < n; k++)
        begin
            req.data  = file_bytes[k];
            req.last  = (k == n - 1);
            req.drain = drain && (k == 0);
            req_q.push_back(req);
        end
        file_bytes.delete();
    endtask

    task automatic queue_random_file(input bit drain);
        wav_req_t req;
        int       n;
        if ($urandom_range(0, 15) == 0)
        begin
            // noise: random bytes with stray end-of-file marks
            n = $urandom_range(1, 12);
            for (int k = 0; k < n; k++)
            begin
                req.data  = 8'($urandom);
                req.last  = (k == n - 1) || ($urandom_range(0, 3) == 0);
                req.drain = drain && (k == 0);
                req_q.push_back(req);
            end
        end
        else
        begin
            push_tag(TAG_RIFF, 1'b1);
            push_le($urandom, 4);
            push_tag(TAG_WAVE, 1'b1);
            for (int c = $urandom_range(0, 2); c > 0; c--)
            begin
                if ($urandom_range(0, 1) == 0)
                    add_other_chunk();
                else
                    add_fmt_chunk();
            end
            if ($urandom_range(0, 7) != 0)
                add_fmt_chunk();
            if ($urandom_range(0, 5) == 0)
            begin
                if ($urandom_range(0, 1) == 0)
                    add_other_chunk();
                else
                    add_fmt_chunk();
            end
            if ($urandom_range(0, 11) != 0)
                add_data_chunk();
            push_random($urandom_range(0, 3));   // trailing bytes after the data
            queue_file(1'b1, drain);
        end
    endtask

    // ------------------------------------------------------------------
    // Sender: bursts of requests with random gaps, fed from req_q
    // ------------------------------------------------------------------
    int unsigned burst_left = 0;
    int unsigned gap_left = 0;

    always @(negedge clk)
    begin
        if (rst_n)
        begin
            // drop the request the parser took at the last rising edge
            if (in_taken)
                req_q.delete(0);
            if (s_axis_tvalid && !in_taken)
                ;   // hold the offered request until it is taken
            else
            begin
                if (burst_left == 0 && gap_left == 0)
                begin
                    burst_left = $urandom_range(1, 16);
                    gap_left = ($urandom_range(0, 2) == 0) ? $urandom_range(1, 6) : 0;
                end
                if (gap_left != 0)
                begin
                    gap_left--;
                    s_axis_tvalid <= 1'b0;
                end
                else if (req_q.size() != 0 &&
                         !(req_q[0].drain && parsed_results_q.size() != 0))
                begin
                    burst_left--;
                    s_axis_tvalid <= 1'b1;
                    s_axis_tdata  <= req_q[0].data;
                    s_axis_tlast  <= req_q[0].last;
                end
                else
                    s_axis_tvalid <= 1'b0;
            end
        end
    end

    // ------------------------------------------------------------------
    // Receiver: ready pattern switches between free flow, random and stall bursts
    // ------------------------------------------------------------------
    int unsigned rx_mode = 0;
    int unsigned rx_left = 0;
    int unsigned stall_left = 0;

    always @(negedge clk)
    begin
        if (rx_left == 0)
        begin
            rx_mode = $urandom_range(0, 2);
            rx_left = $urandom_range(32, 200);
        end
        rx_left--;
        case (rx_mode)
            0: m_axis_tready <= 1'b1;
            1: m_axis_tready <= ($urandom_range(0, 3) != 0);
            default:
            begin
                if (stall_left != 0)
                begin
                    stall_left--;
                    m_axis_tready <= 1'b0;
                end
                else
                begin
                    m_axis_tready <= 1'b1;
                    if ($urandom_range(0, 7) == 0)
                        stall_left = $urandom_range(1, 8);
                end
            end
        endcase
    end

    // ------------------------------------------------------------------
    // Monitor: check results against the oldest expectation, then predict new requests
    // ------------------------------------------------------------------
    always @(posedge clk)
    begin : result_monitor
        wrp_result_t got;
        wrp_result_t want;
        wrp_result_t predicted;
        if (rst_n)
        begin
            if (m_axis_tvalid && m_axis_tready)
            begin
                got = {m_axis_tuser, m_axis_tdata[7:0], m_axis_tdata[23:8],
                       m_axis_tdata[55:24], m_axis_tdata[71:56], m_axis_tdata[103:72]};
                if (parsed_results_q.size() == 0)
                begin
                    error_count++;
                    if (error_count <= 10)
                        $display("%0t: result with no request pending: status %0d", $realtime,
                                 got.status);
                end
                else
                begin
                    want = parsed_results_q.pop_front();
                    if (got !== want)
                    begin
                        error_count++;
                        if (error_count <= 10)
                            $display({"%0t: mismatch (exp/got) status %0d/%0d audio %h/%h ",
                                      "ch %h/%h rate %h/%h bits %h/%h size %h/%h"},
                                     $realtime, want.status, got.status,
                                     want.audio_byte, got.audio_byte,
                                     want.channel_count, got.channel_count,
                                     want.sample_rate, got.sample_rate,
                                     want.bits_per_sample, got.bits_per_sample,
                                     want.data_size, got.data_size);
                    end
                end
            end
            if (s_axis_tvalid && s_axis_tready)
            begin
                parse_wav_byte(s_axis_tdata, s_axis_tlast, predicted);
                parsed_results_q.push_back(predicted);
            end
            in_taken <= s_axis_tvalid && s_axis_tready;
        end
    end

    // ------------------------------------------------------------------
    // Stimulus and end of run
    // ------------------------------------------------------------------
    initial
    begin
        int file_idx;
        clear_parser();

        // Byte extremes, each with end-of-file in the RIFF tag
        file_bytes.push_back(8'hFF);
        queue_file(1'b0, 1'b0);
        file_bytes.push_back(8'h00);
        queue_file(1'b0, 1'b0);
        // Wrong RIFF tag, a byte while holding, then end-of-file while holding
        push_tag(32'h5249_4658, 1'b0);
        file_bytes.push_back(8'h00);
        file_bytes.push_back(8'hFF);
        queue_file(1'b0, 1'b0);
        // File ends inside the size field
        push_tag(TAG_RIFF, 1'b0);
        file_bytes.push_back(8'h00);
        queue_file(1'b0, 1'b0);
        // File ends inside the WAVE tag
        push_tag(TAG_RIFF, 1'b0);
        push_le(32'hFFFF_FFFF, 4);
        file_bytes.push_back(8'h57);
        file_bytes.push_back(8'h41);
        file_bytes.push_back(8'h56);
        queue_file(1'b0, 1'b0);

        // Random files; every sixth one waits for the parser to drain first
        file_idx = 0;
        while (req_q.size() < 1500)
        begin
            queue_random_file(file_idx % 6 == 0);
            file_idx++;
        end

        repeat (8) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        wait (req_q.size() == 0);
        wait (parsed_results_q.size() == 0);
        repeat (10) @(posedge clk);

        if (error_count == 0)
            $display("wav_riff_stream_parser_top_tb: PASS");
        else
            $display("wav_riff_stream_parser_top_tb: FAIL");
        $finish;
    end

    // Give up long after the slowest legal run would have finished
    initial
    begin
        #2_000_000;
        $display("wav_riff_stream_parser_top_tb: FAIL");
        $finish;
    end

endmodule

@@ filelist.f @@
rtl/wrp_pkg.sv
rtl/wrp_parse.sv
rtl/wav_riff_stream_parser_top.sv
verif/wav_riff_stream_parser_top_tb.sv
